// File: hw/rtl/nfid_pkg.sv
// Shared constants, codes and types for the next-fit identifier allocator.
// Used by nfid_find and the allocator unit; it depends on nothing else.

package nfid_pkg;

   // Number of identifier slots; valid identifiers are 1..SLOTS.
   localparam int SLOTS = 127;

   // Port field widths.
   localparam int ACTION_W  = 2;
   localparam int SLOT_ID_W = 7;
   localparam int TAG_W     = 16;
   localparam int STATUS_W  = 3;

   // Internal identifier width, wide enough for SLOTS itself.
   localparam int IDX_W     = $clog2(SLOTS + 1);
   localparam int ID_EXT_W  = (SLOT_ID_W > IDX_W) ? SLOT_ID_W : IDX_W;

   // Free-slot search runs over groups of GRP_W bits.
   localparam int GRP_W     = 16;
   localparam int LOW_W     = $clog2(GRP_W);
   localparam int NUM_GRP   = (SLOTS + 1 + GRP_W - 1) / GRP_W;
   localparam int GRP_SEL_W = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
   localparam int VEC_W     = NUM_GRP * GRP_W;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ALLOC   = 2'd0,
      ACT_PLACE   = 2'd1,
      ACT_RELEASE = 2'd2,
      ACT_LOOKUP  = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_RANGE    = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_ZEROTAG  = 3'd4
   } status_type;

   // Outcome of the free-slot search.
   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] id;
   } find_result_type;

endpackage

// File: hw/rtl/nfid_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.

module nfid_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/nfid_find.sv
// Two-stage circular first-free search over the slot occupancy vector.
// Depends on nfid_pkg for the group sizing and the result struct.

module nfid_find
   import nfid_pkg::*;
(
   input  logic             clock,
   input  logic [VEC_W-1:0] free_vec,
   input  logic [IDX_W-1:0] start_id,
   output find_result_type  result
);

   logic [VEC_W-1:0]   at_or_after;
   logic [NUM_GRP-1:0] any_hi_in, any_all_in;
   logic [LOW_W-1:0]   low_hi_in  [NUM_GRP];
   logic [LOW_W-1:0]   low_all_in [NUM_GRP];
   logic [NUM_GRP-1:0] any_hi_ff, any_all_ff;
   logic [LOW_W-1:0]   low_hi_ff  [NUM_GRP];
   logic [LOW_W-1:0]   low_all_ff [NUM_GRP];

   // Stage one: per group, whether it holds a free slot and the lowest one,
   // both for the part at or after the start and for the whole group.
   always_comb begin
      at_or_after = free_vec & ({VEC_W{1'b1}} << start_id);
      for (int g = 0; g < NUM_GRP; g++) begin
         any_hi_in[g]  = |at_or_after[g*GRP_W +: GRP_W];
         any_all_in[g] = |free_vec[g*GRP_W +: GRP_W];
         low_hi_in[g]  = '0;
         low_all_in[g] = '0;
         for (int b = GRP_W - 1; b >= 0; b--) begin
            if (at_or_after[g*GRP_W + b]) begin
               low_hi_in[g] = LOW_W'(b);
            end
            if (free_vec[g*GRP_W + b]) begin
               low_all_in[g] = LOW_W'(b);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      any_hi_ff  <= any_hi_in;
      any_all_ff <= any_all_in;
      low_hi_ff  <= low_hi_in;
      low_all_ff <= low_all_in;
   end

   // Stage two: the lowest free slot at or after the start wins; failing
   // that, the search wraps round to the lowest free slot overall.
   always_comb begin
      logic [GRP_SEL_W-1:0] grp_hi, grp_all;
      logic [LOW_W-1:0]     pick_low;
      logic [GRP_SEL_W-1:0] pick_grp;
      grp_hi  = '0;
      grp_all = '0;
      for (int g = NUM_GRP - 1; g >= 0; g--) begin
         if (any_hi_ff[g]) begin
            grp_hi = GRP_SEL_W'(g);
         end
         if (any_all_ff[g]) begin
            grp_all = GRP_SEL_W'(g);
         end
      end
      if (|any_hi_ff) begin
         pick_grp = grp_hi;
         pick_low = low_hi_ff[grp_hi];
      end else begin
         pick_grp = grp_all;
         pick_low = low_all_ff[grp_all];
      end
      result.found = |any_all_ff;
      result.id    = IDX_W'({pick_grp, pick_low});
   end

endmodule

// File: hw/rtl/next_fit_id_allocator_unit.sv
// Next-fit identifier allocator. A request is accepted only in the idle state,
// so none is taken until the last has left the execute state, in which its
// response is registered. The cycle in which a request is accepted reads the
// owner tag RAM and reduces the free-slot vector to per-group results; the
// execute state picks the slot and writes the tag and occupancy back. An untaken
// response holds the next request there until rsp_ready. The occupancy bits
// sit in flip-flops cleared by reset; owner tags sit in a RAM with no reset,
// read only for occupied slots. Depends on nfid_pkg, nfid_ram and nfid_find.

module next_fit_id_allocator_unit
   import nfid_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [ACTION_W-1:0]  req_action,
   input  logic [SLOT_ID_W-1:0] req_slot_id,
   input  logic [TAG_W-1:0]     req_owner_tag,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [SLOT_ID_W-1:0] rsp_result_id,
   output logic [TAG_W-1:0]     rsp_result_tag
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type            state_ff;
   logic [SLOTS:0]       valid_ff;
   logic [IDX_W-1:0]     last_ff;
   action_type           action_ff;
   logic                 in_range_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [TAG_W-1:0]     tag_ff;
   logic                 rsp_valid_ff;
   status_type           rsp_status_ff;
   logic [SLOT_ID_W-1:0] rsp_id_ff;
   logic [TAG_W-1:0]     rsp_tag_ff;

   logic [ID_EXT_W-1:0]  req_id_ext;
   logic [IDX_W-1:0]     req_idx;
   logic                 req_in_range;
   logic                 accept;
   logic                 done;
   logic [VEC_W-1:0]     free_vec;
   logic [IDX_W-1:0]     start_id;
   find_result_type      find;
   logic [IDX_W-1:0]     rd_addr;
   logic [TAG_W-1:0]     rd_tag;
   logic                 set_valid, clr_valid, write_tag;
   logic [IDX_W-1:0]     tgt_idx;
   status_type           status_in;
   logic [IDX_W-1:0]     id_in;
   logic [TAG_W-1:0]     tag_in;
   logic [ID_EXT_W-1:0]  id_in_ext;

   assign req_id_ext   = ID_EXT_W'(req_slot_id);
   assign req_idx      = req_id_ext[IDX_W-1:0];
   assign req_in_range = (req_id_ext != '0) && (req_id_ext <= ID_EXT_W'(SLOTS));

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign done      = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);

   // Slot zero and the padding above SLOTS never count as free.
   always_comb begin
      for (int i = 0; i < VEC_W; i++) begin
         free_vec[i] = (i >= 1) && (i <= SLOTS) && !valid_ff[i];
      end
   end

   assign start_id = (last_ff == IDX_W'(SLOTS)) ? IDX_W'(1) : IDX_W'(last_ff + 1'b1);

   nfid_find u_find (
      .clock    (clock),
      .free_vec (free_vec),
      .start_id (start_id),
      .result   (find)
   );

   assign rd_addr = (state_ff == S_IDLE) ? req_idx : idx_ff;

   nfid_ram #(
      .WIDTH (TAG_W),
      .DEPTH (SLOTS + 1)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (done && write_tag),
      .wr_addr (tgt_idx),
      .wr_data (tag_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_tag)
   );

   always_comb begin
      set_valid = 1'b0;
      clr_valid = 1'b0;
      write_tag = 1'b0;
      tgt_idx   = idx_ff;
      status_in = ST_OK;
      id_in     = '0;
      tag_in    = '0;
      if (action_ff == ACT_ALLOC) begin
         tgt_idx = find.id;
         if (tag_ff == '0) begin
            status_in = ST_ZEROTAG;
         end else if (find.found) begin
            set_valid = 1'b1;
            write_tag = 1'b1;
            id_in     = find.id;
         end else begin
            status_in = ST_FULL;
         end
      end else if (!in_range_ff) begin
         status_in = ST_RANGE;
      end else begin
         unique case (action_ff)
            ACT_PLACE: begin
               if (tag_ff == '0) begin
                  status_in = ST_ZEROTAG;
               end else begin
                  set_valid = 1'b1;
                  write_tag = 1'b1;
                  id_in     = idx_ff;
               end
            end
            ACT_RELEASE: begin
               clr_valid = 1'b1;
               id_in     = idx_ff;
            end
            ACT_LOOKUP: begin
               if (valid_ff[idx_ff]) begin
                  id_in  = idx_ff;
                  tag_in = rd_tag;
               end else begin
                  status_in = ST_NOTFOUND;
               end
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
      end
   end

   assign id_in_ext = ID_EXT_W'(id_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (done) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
         if (done) begin
            rsp_valid_ff <= 1'b1;
            if (set_valid) begin
               valid_ff[tgt_idx] <= 1'b1;
               last_ff           <= tgt_idx;
            end
            if (clr_valid) begin
               valid_ff[tgt_idx] <= 1'b0;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         action_ff   <= action_type'(req_action);
         in_range_ff <= req_in_range;
         idx_ff      <= req_idx;
         tag_ff      <= req_owner_tag;
      end
      if (done) begin
         rsp_status_ff <= status_in;
         rsp_id_ff     <= id_in_ext[SLOT_ID_W-1:0];
         rsp_tag_ff    <= tag_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_result_id  = rsp_id_ff;
   assign rsp_result_tag = rsp_tag_ff;

   // Slot zero is reserved and must never be marked occupied.
   a_slot_zero_free: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[0])
      else $error("slot zero marked occupied");

   // The last identifier stays within the table.
   a_last_in_range: assert property (@(posedge clock) disable iff (reset)
      last_ff <= IDX_W'(SLOTS))
      else $error("last identifier beyond table");

   // An allocation only ever claims a slot that was free.
   a_alloc_claims_free: assert property (@(posedge clock) disable iff (reset)
      (done && action_ff == ACT_ALLOC && set_valid) |-> !valid_ff[find.id])
      else $error("allocation claimed an occupied slot");

   // After a successful allocation the claimed slot is occupied and is the last.
   a_alloc_updates: assert property (@(posedge clock) disable iff (reset)
      (done && action_ff == ACT_ALLOC && set_valid)
         |=> (valid_ff[$past(find.id)] && last_ff == $past(find.id)))
      else $error("allocation did not record the claimed slot");

endmodule
